// ----- rtl/frir_pkg.sv -----
// ----------------------------------------------------------------------------
// frir_pkg
// Types, constants and arithmetic helpers shared by the image rescaler.
// ----------------------------------------------------------------------------
`default_nettype none

package frir_pkg;

    localparam int COL_BITS  = 14;  // sample position within a row, widest case
    localparam int ROW_BITS  = 14;  // source row, widest case
    localparam int OUT_BITS  = 13;  // destination row and index
    localparam int VAL_BITS  = 16;
    localparam int SUM_BITS  = 20;
    localparam int CH_SLOTS  = 4;
    localparam int MAX_RES   = 9;
    localparam int CNT_BITS  = 4;

    typedef enum logic [1:0] {
        MODE_QUARTER = 2'd0,
        MODE_HALF    = 2'd1,
        MODE_DOUBLE  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_SCALE_MODE    = 2'd0,
        REG_SOURCE_WIDTH  = 2'd1,
        REG_SOURCE_HEIGHT = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } reg_index_t;

    // Everything the second stage needs to know about one accepted sample.
    typedef struct packed {
        mode_t                 mode;
        logic [VAL_BITS-1:0]   sample;
        logic [1:0]            chan;
        logic                  x_first;
        logic                  x_last;
        logic                  y_first;
        logic                  y_last;
        logic [OUT_BITS-1:0]   row_a;      // 2y-1
        logic [OUT_BITS-1:0]   row_b;      // 2y
        logic [OUT_BITS-1:0]   row_end;    // 2h-1
        logic [OUT_BITS-1:0]   idx_left;   // (2x-1)*ch+c
        logic [OUT_BITS-1:0]   idx_right;  // 2x*ch+c
        logic [OUT_BITS-1:0]   idx_end;    // (2w-1)*ch+c
        logic                  box_active;
        logic                  xk_first;
        logic                  xk_last;
        logic                  yk_first;
        logic                  yk_last;
        logic [OUT_BITS-1:0]   box_idx;
        logic [OUT_BITS-1:0]   box_row;
    } stage_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] row;
        logic [OUT_BITS-1:0] index;
        logic [VAL_BITS-1:0] value;
    } res_t;

    // (3a + b) >> 2
    function automatic logic [VAL_BITS-1:0] mix31(input logic [VAL_BITS-1:0] a,
                                                  input logic [VAL_BITS-1:0] b);
        logic [VAL_BITS+1:0] t;
        t = {1'b0, a, 1'b0} + {2'b00, a} + {2'b00, b};
        return t[VAL_BITS+1:2];
    endfunction

    // (9a + 3b + 3c + d) >> 4
    function automatic logic [VAL_BITS-1:0] mix9331(input logic [VAL_BITS-1:0] a,
                                                    input logic [VAL_BITS-1:0] b,
                                                    input logic [VAL_BITS-1:0] c,
                                                    input logic [VAL_BITS-1:0] d);
        logic [SUM_BITS-1:0] t;
        t = {1'b0, a, 3'b000} + {4'b0000, a}
          + {3'b000, b, 1'b0} + {4'b0000, b}
          + {3'b000, c, 1'b0} + {4'b0000, c}
          + {4'b0000, d};
        return t[SUM_BITS-1:4];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/frir_ram.sv -----
// ----------------------------------------------------------------------------
// frir_ram
// Single-port-write, single-port-read memory with registered read data.
// A write to the address being read in the same cycle is passed through.
// ----------------------------------------------------------------------------
`default_nettype none

module frir_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && waddr == raddr) begin
                rdata <= wdata;
            end else begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/frir_front.sv -----
// ----------------------------------------------------------------------------
// frir_front
// Configuration registers, raster counters and decode of each accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module frir_front
    import frir_pkg::*;
#(
    parameter int MAX_ROW_SAMPLES = 4096,
    parameter int MAX_CHANNELS    = 4,
    parameter int MAX_HEIGHT      = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        accept,
    input  wire logic [15:0] sample,
    output stage_t           stage,
    output logic [COL_BITS-1:0] col
);

    localparam int LIM_BITS = $clog2(MAX_ROW_SAMPLES + 1);
    localparam int LIM1 = MAX_ROW_SAMPLES;
    localparam int LIM2 = MAX_ROW_SAMPLES / 2;
    localparam int LIM3 = MAX_ROW_SAMPLES / 3;
    localparam int LIM4 = MAX_ROW_SAMPLES / 4;
    localparam int HGT_BITS = $clog2(MAX_HEIGHT + 1);

    logic [1:0]  mode_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  chan_reg;

    logic [COL_BITS-1:0] col_reg;
    logic [12:0]         x_reg;
    logic [1:0]          c_reg;
    logic [ROW_BITS-1:0] y_reg;

    logic [2:0]          ch;
    logic [LIM_BITS-1:0] lim;
    logic [12:0]         w;
    logic [HGT_BITS-1:0] h;
    logic [LIM_BITS-1:0] len;
    logic                row_done;
    logic [11:0]         bx;
    logic [12:0]         by;
    logic [12:0]         bw;
    logic [12:0]         bh;
    logic [14:0]         bidx;

    assign col = col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_HALF;
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            chan_reg   <= 3'd3;
        end else if (cfg_wen) begin
            unique case (reg_index_t'(cfg_index))
                REG_SCALE_MODE:    mode_reg   <= cfg_wdata[1:0];
                REG_SOURCE_WIDTH:  width_reg  <= cfg_wdata;
                REG_SOURCE_HEIGHT: height_reg <= cfg_wdata;
                REG_CHANNEL_COUNT: chan_reg   <= cfg_wdata[2:0];
            endcase
        end
    end

    // Effective geometry: out-of-range settings are clamped.
    always_comb begin
        if (chan_reg == 3'd0) begin
            ch = 3'd1;
        end else if (chan_reg > 3'(MAX_CHANNELS)) begin
            ch = 3'(MAX_CHANNELS);
        end else begin
            ch = chan_reg;
        end
        unique case (ch)
            3'd2:    lim = LIM_BITS'(LIM2);
            3'd3:    lim = LIM_BITS'(LIM3);
            3'd4:    lim = LIM_BITS'(LIM4);
            default: lim = LIM_BITS'(LIM1);
        endcase
        if (width_reg == 13'd0) begin
            w = 13'd1;
        end else if (32'(width_reg) > 32'(lim)) begin
            w = 13'(lim);
        end else begin
            w = width_reg;
        end
        if (height_reg == 13'd0) begin
            h = HGT_BITS'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h = HGT_BITS'(MAX_HEIGHT);
        end else begin
            h = HGT_BITS'(height_reg);
        end
        len = LIM_BITS'(32'(w) * 32'(ch));
    end

    assign row_done = 32'(col_reg) == 32'(len) - 1;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wen) begin
            col_reg <= '0;
            x_reg   <= '0;
            c_reg   <= '0;
            y_reg   <= '0;
        end else if (accept) begin
            if (row_done) begin
                col_reg <= '0;
                x_reg   <= '0;
                c_reg   <= '0;
                if (32'(y_reg) == 32'(h) - 1) begin
                    y_reg <= '0;
                end else begin
                    y_reg <= y_reg + 1'b1;
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if ({1'b0, c_reg} == ch - 3'd1) begin
                    c_reg <= '0;
                    x_reg <= x_reg + 1'b1;
                end else begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    // Box geometry: block coordinates and in-range test.
    always_comb begin
        if (mode_reg == MODE_QUARTER) begin
            bx = 12'(x_reg >> 2);
            by = 13'(y_reg >> 2);
            bw = w >> 2;
            bh = 13'(h >> 2);
        end else begin
            bx = x_reg[12:1];
            by = 13'(y_reg >> 1);
            bw = w >> 1;
            bh = 13'(h >> 1);
        end
        bidx = 15'(bx) * 15'(ch) + 15'(c_reg);
    end

    always_comb begin
        stage.mode       = mode_t'(mode_reg);
        stage.sample     = sample;
        stage.chan       = c_reg;
        stage.x_first    = x_reg == 13'd0;
        stage.x_last     = x_reg == w - 13'd1;
        stage.y_first    = y_reg == '0;
        stage.y_last     = 32'(y_reg) == 32'(h) - 1;
        stage.row_a      = OUT_BITS'({y_reg, 1'b0} - 1'b1);
        stage.row_b      = OUT_BITS'({y_reg, 1'b0});
        stage.row_end    = OUT_BITS'({h, 1'b0} - 1'b1);
        stage.idx_left   = OUT_BITS'({col_reg, 1'b0} - COL_BITS'(c_reg) - COL_BITS'(ch));
        stage.idx_right  = OUT_BITS'({col_reg, 1'b0} - COL_BITS'(c_reg));
        stage.idx_end    = OUT_BITS'({len, 1'b0} - LIM_BITS'(ch) + LIM_BITS'(c_reg));
        stage.box_active = (13'(bx) < bw) && (by < bh);
        if (mode_reg == MODE_QUARTER) begin
            stage.xk_first = x_reg[1:0] == 2'd0;
            stage.xk_last  = x_reg[1:0] == 2'd3;
            stage.yk_first = y_reg[1:0] == 2'd0;
            stage.yk_last  = y_reg[1:0] == 2'd3;
        end else begin
            stage.xk_first = !x_reg[0];
            stage.xk_last  = x_reg[0];
            stage.yk_first = !y_reg[0];
            stage.yk_last  = y_reg[0];
        end
        stage.box_idx = OUT_BITS'(bidx);
        stage.box_row = by;
    end

endmodule

`default_nettype wire

// ----- rtl/frir_core.sv -----
// ----------------------------------------------------------------------------
// frir_core
// Second stage: combines the beat with the row stores and neighbour
// registers, builds the list of results and writes the stores back.
// ----------------------------------------------------------------------------
`default_nettype none

module frir_core
    import frir_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                accept,
    input  wire stage_t              stage_in,
    input  wire logic                advance,
    output logic                     busy,
    input  wire logic [VAL_BITS-1:0] prev_rdata,
    input  wire logic [SUM_BITS-1:0] bsum_rdata,
    output logic                     prev_we,
    output logic [VAL_BITS-1:0]      prev_wdata,
    output logic                     bsum_we,
    output logic [SUM_BITS-1:0]      bsum_wdata,
    output res_t                     res_list [MAX_RES],
    output logic [CNT_BITS-1:0]      res_count
);

    stage_t              st_reg;
    logic                busy_reg;
    logic [SUM_BITS-1:0] hsum_reg [CH_SLOTS];
    logic [VAL_BITS-1:0] left_reg [2*CH_SLOTS];

    logic [SUM_BITS-1:0] hsum_next;
    logic [VAL_BITS-1:0] s;
    logic [VAL_BITS-1:0] p;
    logic [VAL_BITS-1:0] pl;
    logic [VAL_BITS-1:0] l;
    logic [VAL_BITS-1:0] edge_a;
    logic [VAL_BITS-1:0] edge_b;
    logic [CNT_BITS-1:0] n;
    logic                is_box;

    assign busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (advance) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_reg <= stage_in;
        end
    end

    assign s      = st_reg.sample;
    assign p      = prev_rdata;
    assign pl     = left_reg[{1'b1, st_reg.chan}];
    assign l      = left_reg[{1'b0, st_reg.chan}];
    assign edge_a = mix31(p, s);
    assign edge_b = mix31(s, p);
    assign is_box = (st_reg.mode == MODE_QUARTER) || (st_reg.mode == MODE_HALF);

    assign hsum_next = st_reg.xk_first ? SUM_BITS'(s) : hsum_reg[st_reg.chan] + SUM_BITS'(s);
    assign bsum_wdata = st_reg.yk_first ? hsum_next : bsum_rdata + hsum_next;
    assign bsum_we    = advance && is_box && st_reg.box_active && st_reg.xk_last;
    assign prev_we    = advance && st_reg.mode == MODE_DOUBLE;
    assign prev_wdata = s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CH_SLOTS; i++) begin
                hsum_reg[i] <= '0;
            end
            for (int i = 0; i < 2*CH_SLOTS; i++) begin
                left_reg[i] <= '0;
            end
        end else if (advance) begin
            if (is_box && st_reg.box_active) begin
                hsum_reg[st_reg.chan] <= hsum_next;
            end
            if (st_reg.mode == MODE_DOUBLE) begin
                left_reg[{1'b0, st_reg.chan}] <= s;
                left_reg[{1'b1, st_reg.chan}] <= p;
            end
        end
    end

    // Result list in emission order.
    always_comb begin
        n = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res_list[i] = '0;
        end
        if (is_box) begin
            if (st_reg.box_active && st_reg.xk_last && st_reg.yk_last) begin
                res_list[0].row   = st_reg.box_row;
                res_list[0].index = st_reg.box_idx;
                res_list[0].value = (st_reg.mode == MODE_QUARTER)
                                    ? VAL_BITS'(bsum_wdata >> 4) : VAL_BITS'(bsum_wdata >> 2);
                n = CNT_BITS'(1);
            end
        end else if (st_reg.mode == MODE_DOUBLE) begin
            if (st_reg.y_first) begin
                if (st_reg.x_first) begin
                    res_list[n] = '{row: '0, index: OUT_BITS'(st_reg.chan), value: s};
                    n = n + 1'b1;
                end else begin
                    res_list[n] = '{row: '0, index: st_reg.idx_left, value: mix31(l, s)};
                    n = n + 1'b1;
                    res_list[n] = '{row: '0, index: st_reg.idx_right, value: mix31(s, l)};
                    n = n + 1'b1;
                end
                if (st_reg.x_last) begin
                    res_list[n] = '{row: '0, index: st_reg.idx_end, value: s};
                    n = n + 1'b1;
                end
            end else begin
                if (st_reg.x_first) begin
                    res_list[n] = '{row: st_reg.row_a, index: OUT_BITS'(st_reg.chan),
                                    value: edge_a};
                    n = n + 1'b1;
                end else begin
                    res_list[n] = '{row: st_reg.row_a, index: st_reg.idx_left,
                                    value: mix9331(pl, p, l, s)};
                    n = n + 1'b1;
                    res_list[n] = '{row: st_reg.row_a, index: st_reg.idx_right,
                                    value: mix9331(p, pl, s, l)};
                    n = n + 1'b1;
                end
                if (st_reg.x_last) begin
                    res_list[n] = '{row: st_reg.row_a, index: st_reg.idx_end, value: edge_a};
                    n = n + 1'b1;
                end
                if (st_reg.x_first) begin
                    res_list[n] = '{row: st_reg.row_b, index: OUT_BITS'(st_reg.chan),
                                    value: edge_b};
                    n = n + 1'b1;
                end else begin
                    res_list[n] = '{row: st_reg.row_b, index: st_reg.idx_left,
                                    value: mix9331(l, s, pl, p)};
                    n = n + 1'b1;
                    res_list[n] = '{row: st_reg.row_b, index: st_reg.idx_right,
                                    value: mix9331(s, l, p, pl)};
                    n = n + 1'b1;
                end
                if (st_reg.x_last) begin
                    res_list[n] = '{row: st_reg.row_b, index: st_reg.idx_end, value: edge_b};
                    n = n + 1'b1;
                end
            end
            if (st_reg.y_last) begin
                if (st_reg.x_first) begin
                    res_list[n] = '{row: st_reg.row_end, index: OUT_BITS'(st_reg.chan),
                                    value: s};
                    n = n + 1'b1;
                end else begin
                    res_list[n] = '{row: st_reg.row_end, index: st_reg.idx_left,
                                    value: mix31(l, s)};
                    n = n + 1'b1;
                    res_list[n] = '{row: st_reg.row_end, index: st_reg.idx_right,
                                    value: mix31(s, l)};
                    n = n + 1'b1;
                end
                if (st_reg.x_last) begin
                    res_list[n] = '{row: st_reg.row_end, index: st_reg.idx_end, value: s};
                    n = n + 1'b1;
                end
            end
        end
        res_count = n;
    end

endmodule

`default_nettype wire

// ----- rtl/frir_emit.sv -----
// ----------------------------------------------------------------------------
// frir_emit
// Result buffer: holds the results of one beat and sends them one a cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module frir_emit
    import frir_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pending,
    input  wire res_t                res_list [MAX_RES],
    input  wire logic [CNT_BITS-1:0] res_count,
    output logic                     load,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [47:0]              m_tdata,
    output logic                     m_tlast
);

    res_t                buf_reg [MAX_RES];
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] ptr_reg;
    logic                empty;
    res_t                head;

    assign empty    = ptr_reg == cnt_reg;
    assign m_tvalid = !empty;
    assign m_tlast  = ptr_reg == cnt_reg - 1'b1;
    assign load     = pending && (empty || (m_tready && m_tlast));
    assign head     = buf_reg[ptr_reg];
    assign m_tdata  = {6'b000000, head.value, head.index, head.row};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end else if (load) begin
            cnt_reg <= res_count;
            ptr_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RES; i++) begin
                buf_reg[i] <= res_list[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fixed_ratio_image_rescale.sv -----
// ----------------------------------------------------------------------------
// fixed_ratio_image_rescale
// Streaming image rescaler: 4x4 or 2x2 box average, or 2x bilinear upscale; MODE_NONE emits nothing.
// ----------------------------------------------------------------------------
// Source samples arrive one per beat in raster order with channels
// interleaved. Each accepted beat produces between zero and nine result beats
// (destination row, index and value), the last of which carries m_tlast. A
// beat passes through two stages: the first decodes its position and reads
// the two row memories, the second combines the read data with the
// per-channel neighbour registers, writes back and hands its results to a
// buffer that sends one result a cycle while m_tready is high. The next
// source beat is taken while the previous results drain, so the single
// result port sets the pace when a beat yields more than one result. Any
// configuration write restarts the frame; it must only be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_ratio_image_rescale
    import frir_pkg::*;
#(
    parameter int MAX_ROW_SAMPLES = 4096,
    parameter int MAX_CHANNELS    = 4,
    parameter int SAMPLE_BITS     = 16,
    parameter int MAX_HEIGHT      = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // sample[15:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_row[12:0], out_index[25:13], out_value[41:26]
    output logic             m_tlast    // last_of_run
);

    localparam int PREV_DEPTH = MAX_ROW_SAMPLES;
    localparam int BSUM_DEPTH = MAX_ROW_SAMPLES / 2;
    localparam int PA = $clog2(PREV_DEPTH);
    localparam int BA = $clog2(BSUM_DEPTH);

    logic                accept;
    logic                load;
    logic                busy;
    logic [15:0]         sample;
    stage_t              stage;
    logic [VAL_BITS-1:0] prev_rdata;
    logic [SUM_BITS-1:0] bsum_rdata;
    logic                prev_we;
    logic [VAL_BITS-1:0] prev_wdata;
    logic                bsum_we;
    logic [SUM_BITS-1:0] bsum_wdata;
    logic [PA-1:0]       prev_waddr_reg;
    logic [BA-1:0]       bsum_waddr_reg;
    res_t                res_list [MAX_RES];
    logic [CNT_BITS-1:0] res_count;
    logic [COL_BITS-1:0] col;

    // The sample is cut to its configured width before anything else.
    assign sample   = 16'(s_tdata[SAMPLE_BITS-1:0]);
    assign s_tready = !busy || load;
    assign accept   = s_tvalid && s_tready;

    // The front end also reports the row position of the beat, which is the
    // previous-row address in double mode.
    frir_front #(
        .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES),
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_HEIGHT      (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .sample    (sample),
        .stage     (stage),
        .col       (col)
    );

    // Write addresses follow the beat into the second stage.
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_waddr_reg <= PA'(col);
            bsum_waddr_reg <= BA'(stage.box_idx);
        end
    end

    frir_ram #(.DEPTH(PREV_DEPTH), .WIDTH(VAL_BITS)) u_prev_row (
        .aclk  (aclk),
        .re    (accept),
        .raddr (PA'(col)),
        .rdata (prev_rdata),
        .we    (prev_we),
        .waddr (prev_waddr_reg),
        .wdata (prev_wdata)
    );

    frir_ram #(.DEPTH(BSUM_DEPTH), .WIDTH(SUM_BITS)) u_block_sum (
        .aclk  (aclk),
        .re    (accept),
        .raddr (BA'(stage.box_idx)),
        .rdata (bsum_rdata),
        .we    (bsum_we),
        .waddr (bsum_waddr_reg),
        .wdata (bsum_wdata)
    );

    frir_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .stage_in   (stage),
        .advance    (load),
        .busy       (busy),
        .prev_rdata (prev_rdata),
        .bsum_rdata (bsum_rdata),
        .prev_we    (prev_we),
        .prev_wdata (prev_wdata),
        .bsum_we    (bsum_we),
        .bsum_wdata (bsum_wdata),
        .res_list   (res_list),
        .res_count  (res_count)
    );

    frir_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pending   (busy),
        .res_list  (res_list),
        .res_count (res_count),
        .load      (load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
